>>> rtl/mpva_pkg.sv
package mpva_pkg;

    localparam int VOICES   = 8;
    localparam int VIDX_W   = $clog2(VOICES);
    localparam int CNT_W    = $clog2(VOICES + 1);
    localparam int VOICE_FW = 3;

    localparam logic [7:0] MSG_NOTE_ON  = 8'h90;
    localparam logic [7:0] MSG_NOTE_OFF = 8'h80;
    localparam logic [7:0] CHAN_MASK    = 8'h07;

    localparam logic ACT_RELEASE = 1'b0;
    localparam logic ACT_START   = 1'b1;

    typedef logic [VIDX_W-1:0] vidx_t;
    typedef logic [VOICES-1:0] vmask_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] channel_byte;
        logic [6:0] note;
        logic [6:0] velocity;
    } in_word_t;

    typedef struct packed {
        logic [VOICE_FW-1:0] voice;
        logic                action;
        logic [6:0]          pitch;
        logic [4:0]          level;
        logic                last;
    } out_word_t;

    typedef struct packed {
        logic cap_msg;
        logic load_pend;
        logic emit_steal;
        logic emit_start;
        logic emit_rel;
    } dp_cmd_t;

    typedef struct packed {
        logic is_start;
        logic is_release;
        logic any_match;
        logic full;
        logic out_free;
        logic pend_last;
    } dp_stat_t;

    // Advance a ring pointer, wrapping at VOICES.
    function automatic vidx_t ring_next(vidx_t p);
        vidx_t r;
        if (p == vidx_t'(VOICES - 1)) begin
            r = '0;
        end else begin
            r = vidx_t'(p + 1'b1);
        end
        return r;
    endfunction

endpackage

>>> rtl/mpva_dp.sv
module mpva_dp import mpva_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_word_t  s_data,
    input  logic      m_ready,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output out_word_t m_data,
    output logic      m_valid
);

    in_word_t  msg_reg;
    vidx_t     ring_reg [VOICES];
    vidx_t     head_reg;
    vidx_t     tail_reg;
    cnt_t      busy_reg;
    logic [6:0] note_reg [VOICES];
    vmask_t    sound_reg;
    vmask_t    pend_reg;
    out_word_t out_reg;
    logic      out_valid_reg;

    vmask_t    match;
    vmask_t    pend_rest;
    vidx_t     sel;
    vidx_t     head_voice;
    logic      chan_ok;
    logic      is_on;
    logic      is_off;
    logic      full;
    logic      any_emit;

    assign chan_ok    = (msg_reg.channel_byte & CHAN_MASK) == 8'h00;
    assign is_on      = msg_reg.command == MSG_NOTE_ON;
    assign is_off     = msg_reg.command == MSG_NOTE_OFF;
    assign full       = busy_reg >= cnt_t'(VOICES);
    assign head_voice = ring_reg[head_reg];
    assign pend_rest  = pend_reg & (pend_reg - 1'b1);
    assign any_emit   = cmd.emit_steal | cmd.emit_start | cmd.emit_rel;

    // Only sounding voices match the note.
    always_comb begin
        for (int i = 0; i < VOICES; i++) begin
            match[i] = sound_reg[i] && (note_reg[i] == msg_reg.note);
        end
    end

    // Lowest pending voice goes first.
    always_comb begin
        sel = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (pend_reg[i]) begin
                sel = vidx_t'(i);
            end
        end
    end

    always_comb begin
        stat.is_start   = chan_ok && is_on && (msg_reg.velocity != 7'd0);
        stat.is_release = chan_ok && (is_off || (is_on && (msg_reg.velocity == 7'd0)));
        stat.any_match  = |match;
        stat.full       = full;
        stat.out_free   = !out_valid_reg || m_ready;
        stat.pend_last  = pend_rest == '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VOICES; i++) begin
                ring_reg[i] <= vidx_t'(i);
                note_reg[i] <= '0;
            end
            head_reg      <= '0;
            tail_reg      <= '0;
            busy_reg      <= '0;
            sound_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit_start) begin
                note_reg[head_voice]  <= msg_reg.note;
                sound_reg[head_voice] <= 1'b1;
                if (!full) begin
                    head_reg <= ring_next(head_reg);
                    busy_reg <= cnt_t'(busy_reg + 1'b1);
                end
            end
            if (cmd.emit_rel) begin
                sound_reg[sel]     <= 1'b0;
                note_reg[sel]      <= '0;
                ring_reg[tail_reg] <= sel;
                tail_reg           <= ring_next(tail_reg);
                if (busy_reg != '0) begin
                    busy_reg <= cnt_t'(busy_reg - 1'b1);
                end
            end
            if (any_emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_msg) begin
            msg_reg <= s_data;
        end
        if (cmd.load_pend) begin
            pend_reg <= match;
        end else if (cmd.emit_rel) begin
            pend_reg <= pend_rest;
        end
        if (cmd.emit_steal) begin
            out_reg.voice  <= VOICE_FW'(head_voice);
            out_reg.action <= ACT_RELEASE;
            out_reg.pitch  <= '0;
            out_reg.level  <= '0;
            out_reg.last   <= 1'b0;
        end else if (cmd.emit_start) begin
            out_reg.voice  <= VOICE_FW'(head_voice);
            out_reg.action <= ACT_START;
            out_reg.pitch  <= msg_reg.note;
            out_reg.level  <= msg_reg.velocity[6:2];
            out_reg.last   <= 1'b1;
        end else if (cmd.emit_rel) begin
            out_reg.voice  <= VOICE_FW'(sel);
            out_reg.action <= ACT_RELEASE;
            out_reg.pitch  <= '0;
            out_reg.level  <= '0;
            out_reg.last   <= pend_rest == '0;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

endmodule

>>> rtl/mpva_ctrl.sv
module mpva_ctrl import mpva_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  dp_stat_t stat,
    output logic     s_ready,
    output dp_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECODE  = 3'd1;
    localparam logic [2:0] ST_STEAL   = 3'd2;
    localparam logic [2:0] ST_START   = 3'd3;
    localparam logic [2:0] ST_RELEASE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Hold ready low while reset is applied.
    assign s_ready = aresetn && (state_reg == ST_IDLE);

    always_comb begin
        cmd.cap_msg    = s_valid && s_ready;
        cmd.load_pend  = state_reg == ST_DECODE;
        cmd.emit_steal = (state_reg == ST_STEAL) && stat.out_free;
        cmd.emit_start = (state_reg == ST_START) && stat.out_free;
        cmd.emit_rel   = (state_reg == ST_RELEASE) && stat.out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (stat.is_start) begin
                    state_next = stat.full ? ST_STEAL : ST_START;
                end else if (stat.is_release && stat.any_match) begin
                    state_next = ST_RELEASE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEAL: begin
                if (stat.out_free) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RELEASE: begin
                if (stat.out_free && stat.pend_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/midi_poly_voice_allocator_unit.sv
// Polyphonic voice allocator: takes one MIDI note word per handshake and acts only on
// channel 0 (low three bits of channel_byte). A note-on with nonzero velocity starts a
// voice taken from a ring of free voices; when all voices are busy the voice at the
// ring head is stolen and a release word precedes its start word. A note-off, or a
// note-on with velocity zero, releases every sounding voice holding that note, lowest
// voice first, and returns each one to the ring. Each result word carries the voice,
// the action (release or start), pitch, level (velocity / 4) and a last flag on the
// final word for that message. Each result word waits for the output register to be
// free. The sequencer handles one message at a time and emits at most one word per
// cycle through a single output register, and only while that register is free, so a
// new message is taken while the last word of the previous one still waits at the
// output.
module midi_poly_voice_allocator_unit import mpva_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // Sequence decode, steal, start and release steps.
    mpva_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (dp_stat),
        .s_ready (s_ready),
        .cmd     (dp_cmd)
    );

    // Hold the voice ring, per-voice notes and the output register.
    mpva_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .cmd     (dp_cmd),
        .stat    (dp_stat),
        .m_data  (m_data),
        .m_valid (m_valid)
    );

    // At most one result word is produced per cycle.
    a_one_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({dp_cmd.emit_steal, dp_cmd.emit_start, dp_cmd.emit_rel}))
        else $error("more than one emit command at once");

    // Never overwrite a word still waiting at the output.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.emit_steal || dp_cmd.emit_start || dp_cmd.emit_rel)
            |-> (!m_valid || m_ready))
        else $error("result word overwritten before it was taken");

    // The cycle after a message is taken is spent decoding it.
    a_decode_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !(dp_cmd.emit_steal || dp_cmd.emit_start
            || dp_cmd.emit_rel || s_ready))
        else $error("no decode cycle after accepting a message");

    // A stolen voice is always restarted right after its release.
    a_steal_start: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.emit_steal |=> !s_ready)
        else $error("steal release not followed by a start");

endmodule

>>> sim/tb_midi_poly_voice_allocator_unit.sv
`timescale 1ns / 100ps

import mpva_pkg::*;

// Scoreboard: keeps its own picture of the free-voice ring and of which voice
// sounds which note, turns each accepted message word into the voice command
// words it must cause, and checks the block's result words against them in order.
class voice_cmd_scoreboard;
    vidx_t       free_ring [VOICES];
    vidx_t       ring_head;
    vidx_t       ring_tail;
    int          busy_count;
    logic [6:0]  voice_note [VOICES];
    logic        voice_sounding [VOICES];
    out_word_t   expected_cmds [$];
    int          errors;
    int          messages;
    int          acting_messages;
    int          cmds_checked;
    int          steals;
    int          widest_release;

    function new();
        for (int i = 0; i < VOICES; i++) begin
            free_ring[i]      = vidx_t'(i);
            voice_note[i]     = '0;
            voice_sounding[i] = 1'b0;
        end
        ring_head       = '0;
        ring_tail       = '0;
        busy_count      = 0;
        errors          = 0;
        messages        = 0;
        acting_messages = 0;
        cmds_checked    = 0;
        steals          = 0;
        widest_release  = 0;
    endfunction

    function vidx_t bump(vidx_t p);
        return (p == vidx_t'(VOICES - 1)) ? vidx_t'(0) : vidx_t'(p + 1'b1);
    endfunction

    function out_word_t make_cmd(vidx_t v, logic act, logic [6:0] pitch, logic [4:0] level);
        out_word_t c;
        c.voice  = VOICE_FW'(v);
        c.action = act;
        c.pitch  = pitch;
        c.level  = level;
        c.last   = 1'b0;
        return c;
    endfunction

    // Work out the command words one accepted message causes and queue them.
    function void note_message(in_word_t w);
        out_word_t cmds [$];
        out_word_t c;
        vidx_t     v;
        int        released;
        messages++;
        if ((w.channel_byte & CHAN_MASK) != 8'h00) begin
            return;
        end
        if (w.command != MSG_NOTE_ON && w.command != MSG_NOTE_OFF) begin
            return;
        end
        acting_messages++;
        if (w.command == MSG_NOTE_ON && w.velocity != 7'd0) begin
            v = free_ring[ring_head];
            if (busy_count >= VOICES) begin
                // every voice taken: steal the one at the ring head
                cmds.push_back(make_cmd(v, ACT_RELEASE, 7'd0, 5'd0));
                steals++;
            end else begin
                ring_head = bump(ring_head);
                busy_count++;
            end
            voice_note[v]     = w.note;
            voice_sounding[v] = 1'b1;
            cmds.push_back(make_cmd(v, ACT_START, w.note, w.velocity[6:2]));
        end else begin
            // only sounding voices match, lowest voice first
            released = 0;
            for (int i = 0; i < VOICES; i++) begin
                if (voice_sounding[i] && voice_note[i] == w.note) begin
                    cmds.push_back(make_cmd(vidx_t'(i), ACT_RELEASE, 7'd0, 5'd0));
                    voice_sounding[i]    = 1'b0;
                    voice_note[i]        = '0;
                    free_ring[ring_tail] = vidx_t'(i);
                    ring_tail            = bump(ring_tail);
                    if (busy_count > 0) begin
                        busy_count--;
                    end
                    released++;
                end
            end
            if (released > widest_release) begin
                widest_release = released;
            end
        end
        for (int i = 0; i < cmds.size(); i++) begin
            c      = cmds[i];
            c.last = (i == cmds.size() - 1);
            expected_cmds.push_back(c);
        end
    endfunction

    function void report(string field, int exp_val, int act_val);
        errors++;
        $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
    endfunction

    // Compare one result word with the oldest expected command.
    function void check_command(out_word_t got);
        out_word_t exp_cmd;
        cmds_checked++;
        if (expected_cmds.size() == 0) begin
            errors++;
            $error("unexpected command word: voice %0d action %0d pitch %0d level %0d last %0d",
                   got.voice, got.action, got.pitch, got.level, got.last);
            return;
        end
        exp_cmd = expected_cmds.pop_front();
        if (got.voice !== exp_cmd.voice)   report("voice", exp_cmd.voice, got.voice);
        if (got.action !== exp_cmd.action) report("action", exp_cmd.action, got.action);
        if (got.pitch !== exp_cmd.pitch)   report("pitch", exp_cmd.pitch, got.pitch);
        if (got.level !== exp_cmd.level)   report("level", exp_cmd.level, got.level);
        if (got.last !== exp_cmd.last)     report("last", exp_cmd.last, got.last);
    endfunction

    function int pending();
        return expected_cmds.size();
    endfunction
endclass

module tb_midi_poly_voice_allocator_unit;

    localparam int STALL_LIMIT  = 5000;  // cycles without any handshake
    localparam int SETTLE_WAIT  = 20;    // quiet cycles after the last result
    localparam int HOLD_OFF_LEN = 300;   // long receiver hold-off
    localparam int PHASE_ITEMS  = 90;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    voice_cmd_scoreboard sb = new();

    int send_idle_pct;   // chance per cycle that the sender sits idle
    int recv_stall_pct;  // chance per cycle that the receiver stalls
    int hold_left;       // remaining cycles of a forced receiver hold-off
    int quiet_cycles;

    midi_poly_voice_allocator_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Receiver: drive ready at the falling edge; a hold-off overrides the
    // random stalls and counts itself down here.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Check every result word taken at a rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_command(m_data);
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one message word; hold valid and payload until the block takes it.
    // Valid stays high on return so a back-to-back word needs no low cycle.
    task automatic send_message(in_word_t w);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_message(w);
    endtask

    task automatic send_fields(logic [7:0] cmd, logic [7:0] chan, int note, int vel);
        in_word_t w;
        w.command      = cmd;
        w.channel_byte = chan;
        w.note         = 7'(note);
        w.velocity     = 7'(vel);
        send_message(w);
    endtask

    // Drop valid and wait until every expected command word has come back.
    task automatic drain_commands();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Mostly a small pool of notes so that releases find their voices.
    function automatic logic [6:0] pick_note();
        if ($urandom_range(0, 99) < 75) begin
            return 7'(48 + $urandom_range(0, 11));
        end
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic in_word_t random_message();
        in_word_t w;
        int       r;
        r              = $urandom_range(0, 99);
        w.note         = pick_note();
        w.velocity     = 7'($urandom_range(1, 127));
        w.channel_byte = {5'($urandom_range(0, 31)), 3'b000};
        if (r < 45) begin
            w.command = MSG_NOTE_ON;
            if (r < 3) begin
                w.velocity = 7'd0;
            end
        end else if (r < 80) begin
            // note off, either as its own status or as a zero-velocity note on
            if ($urandom_range(0, 1) == 1) begin
                w.command  = MSG_NOTE_OFF;
                w.velocity = 7'($urandom_range(0, 127));
            end else begin
                w.command  = MSG_NOTE_ON;
                w.velocity = 7'd0;
            end
        end else if (r < 90) begin
            w.command      = ($urandom_range(0, 1) == 1) ? MSG_NOTE_ON : MSG_NOTE_OFF;
            w.channel_byte = 8'($urandom_range(0, 255)) | 8'($urandom_range(1, 7));
        end else begin
            // noise: any status byte, any channel
            w.command      = 8'($urandom_range(0, 255));
            w.channel_byte = 8'($urandom_range(0, 255));
            w.note         = 7'($urandom_range(0, 127));
            w.velocity     = 7'($urandom_range(0, 127));
        end
        return w;
    endfunction

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, no idling on either side.
        // note-off of note 0 while every voice is idle: must free nothing
        send_fields(MSG_NOTE_OFF, 8'h00, 0, 0);
        send_fields(MSG_NOTE_ON, 8'h00, 0, 127);
        // upper channel bits are ignored; velocity below four gives level zero
        send_fields(MSG_NOTE_ON, 8'hF8, 127, 1);
        send_fields(MSG_NOTE_ON, 8'h00, 64, 4);
        // other channels
        send_fields(MSG_NOTE_ON, 8'h07, 10, 100);
        send_fields(MSG_NOTE_OFF, 8'h01, 0, 64);
        // other status bytes
        send_fields(8'h00, 8'h00, 0, 127);
        send_fields(8'hFF, 8'h00, 127, 127);
        send_fields(8'hA0, 8'h00, 64, 10);
        send_fields(8'h91, 8'h00, 64, 10);
        // zero-velocity note on and plain note off, then an unmatched one
        send_fields(MSG_NOTE_ON, 8'h00, 127, 0);
        send_fields(MSG_NOTE_OFF, 8'h00, 0, 127);
        send_fields(MSG_NOTE_OFF, 8'h00, 0, 0);
        // fill every voice with one note and steal past the end
        for (int k = 0; k < 9; k++) begin
            send_fields(MSG_NOTE_ON, 8'h00, 50, k * 14 + 15);
        end
        // one message releasing many voices at once
        send_fields(MSG_NOTE_OFF, 8'h00, 50, 0);
        send_fields(MSG_NOTE_OFF, 8'h00, 64, 0);
        drain_commands();

        // Random part in four idling phases; drain between phases.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold the receiver off while the sender keeps pushing
                if (ph == 0 && n == 10) begin
                    hold_left = HOLD_OFF_LEN;
                end
                send_message(random_message());
            end
            drain_commands();
        end

        repeat (SETTLE_WAIT) @(posedge aclk);

        $display("Sent %0d messages (%0d on channel 0 note on/off), checked %0d command words",
                 sb.messages, sb.acting_messages, sb.cmds_checked);
        $display("Voice steals: %0d, most voices freed by one message: %0d",
                 sb.steals, sb.widest_release);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
